/* design/bhs_pkg.sv */
`timescale 1ns / 1ps

package bhs_pkg;

	// Q2.14 full scale, carried by a held button
	localparam logic signed [15:0] Q_ONE = 16'sd16384;

	localparam int unsigned NUM_AXES = 6;
	localparam int unsigned AXIS_W   = 3;
	localparam int unsigned CODE_W   = 5;

	// Last axis index, which closes a snapshot
	localparam logic [AXIS_W-1:0] AXIS_LAST = 3'd5;

	// Sample kinds
	localparam logic KIND_DIGITAL = 1'b0;
	localparam logic KIND_AXIS    = 1'b1;

	typedef struct packed {
		logic [31:0]        button_mask;
		logic [63:0]        source_time;
		logic [63:0]        state_time;
		logic               make_edges;
		logic signed [15:0] left_x;
		logic signed [15:0] left_y;
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] left_trig;
		logic signed [15:0] right_trig;
	} bhs_snap_t;

	typedef struct packed {
		logic               sample_kind;
		logic [4:0]         sample_code;
		logic               is_down;
		logic               is_pressed;
		logic               is_released;
		logic signed [15:0] scalar_value;
		logic [63:0]        hold_start;
		logic [63:0]        sample_time;
		logic               last_sample;
	} bhs_sample_t;

	// What one button lane found for the current snapshot
	typedef struct packed {
		logic        emit;
		logic        down;
		logic        pressed;
		logic        released;
		logic [63:0] hold;
	} bhs_lane_res_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_AXIS = 3'b100
	} bhs_state_t;

endpackage

/* design/bhs_if.sv */
`timescale 1ns / 1ps

// Snapshot channel
interface bhs_snap_if;
	logic                valid;
	logic                ready;
	bhs_pkg::bhs_snap_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// Sample channel
interface bhs_sample_if;
	logic                 valid;
	logic                 ready;
	bhs_pkg::bhs_sample_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* design/button_edge_hold_sampler_unit.sv */
`timescale 1ns / 1ps
// Button edge and hold sampler.
// snap (sink): one gamepad snapshot per transfer, button mask, two timestamps,
//   an edge-synthesis flag and six Q2.14 axis values.
// sample (source): the control samples of that snapshot, one per transfer:
//   a digital sample for each held button and each released button with a
//   release edge, in button order, then six axis samples, the last one marked.
// One lane per button keeps its press time and works out its sample in the
//   cycle the snapshot is taken; a merge sequencer then visits one lane per
//   cycle and one axis per cycle while the output is not stalled.
// snap.ready is high only while the sequencer is idle, so a new snapshot is
//   taken only after the last axis sample of the previous one is loaded.
// A stalled receiver holds the output register; the sequencer skips buttons
//   without a sample but waits on each sample that it must deliver.
// Reset clears the previous mask and every stored press time, and empties
//   the output register.
module button_edge_hold_sampler_unit #(
	parameter int NUM_BUTTONS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	bhs_snap_if.sink     snap,
	bhs_sample_if.source sample
);
	import bhs_pkg::*;

	logic                   accept;
	logic                   idle;
	logic [63:0]            t;
	logic [NUM_BUTTONS-1:0] cur;
	logic [NUM_BUTTONS-1:0] prev_mask_q;
	bhs_lane_res_t          lane_res [NUM_BUTTONS];

	assign snap.ready = idle;
	assign accept     = snap.valid && idle;
	assign cur        = snap.data.button_mask[NUM_BUTTONS-1:0];
	assign t          = (snap.data.source_time != 64'd0) ?
	                    snap.data.source_time : snap.data.state_time;

	// Hold the mask of the last snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mask_q <= '0;
		end else if (accept) begin
			prev_mask_q <= cur;
		end
	end

	// One lane per button
	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		bhs_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (accept),
			.down   (cur[i]),
			.prev   (prev_mask_q[i]),
			.synth  (snap.data.make_edges),
			.t      (t),
			.res    (lane_res[i])
		);
	end

	bhs_merge #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.snap     (snap.data),
		.t        (t),
		.lane_res (lane_res),
		.idle     (idle),
		.sample   (sample)
	);

endmodule

/* design/bhs_lane.sv */
`timescale 1ns / 1ps

module bhs_lane (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic                   down,
	input  logic                   prev,
	input  logic                   synth,
	input  logic [63:0]            t,
	output bhs_pkg::bhs_lane_res_t res
);
	import bhs_pkg::*;

	logic        press_edge;
	logic        release_edge;
	logic        have_time;
	logic [63:0] press_time_q;
	logic [63:0] held_time;
	logic [63:0] press_time_d;

	// Decide the edges against the previous mask
	assign press_edge   = synth & down & ~prev;
	assign release_edge = synth & ~down & prev;
	assign have_time    = (press_time_q != 64'd0);

	// Record the time on a press or when nothing is stored
	assign held_time = (press_edge || !have_time) ? t : press_time_q;

	always_comb begin
		press_time_d = press_time_q;
		if (down) begin
			press_time_d = held_time;
		end else if (release_edge || (prev && !synth)) begin
			press_time_d = 64'd0;
		end
	end

	// Hold the stored press time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_time_q <= 64'd0;
		end else if (load) begin
			press_time_q <= press_time_d;
		end
	end

	// Register this lane's sample for the merge stage
	always_ff @(posedge clk) begin
		if (load) begin
			res.emit     <= down | release_edge;
			res.down     <= down;
			res.pressed  <= press_edge;
			res.released <= release_edge;
			res.hold     <= down ? held_time : (have_time ? press_time_q : t);
		end
	end

endmodule

/* design/bhs_merge.sv */
`timescale 1ns / 1ps

module bhs_merge #(
	parameter int NUM_BUTTONS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  bhs_pkg::bhs_snap_t     snap,
	input  logic [63:0]            t,
	input  bhs_pkg::bhs_lane_res_t lane_res [NUM_BUTTONS],
	output logic                   idle,
	bhs_sample_if.source           sample
);
	import bhs_pkg::*;

	localparam int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUTTONS - 1);

	bhs_state_t         state_q;
	logic [IW-1:0]      idx_q;
	logic [AXIS_W-1:0]  ax_q;
	logic [63:0]        t_q;
	logic signed [15:0] axis_q [NUM_AXES];
	logic               out_valid_q;
	bhs_sample_t        out_q;

	logic               free;
	bhs_lane_res_t      cur;
	logic signed [15:0] ax_val;
	logic               load_dig;
	logic               load_axis;
	logic               advance;

	assign free   = !out_valid_q || sample.ready;
	assign cur    = lane_res[idx_q];
	assign ax_val = axis_q[ax_q];

	assign load_dig  = (state_q == ST_SCAN) && cur.emit && free;
	assign advance   = (state_q == ST_SCAN) && (!cur.emit || free);
	assign load_axis = (state_q == ST_AXIS) && free;

	assign idle         = (state_q == ST_IDLE);
	assign sample.valid = out_valid_q;
	assign sample.data  = out_q;

	// Capture snapshot time and axes
	always_ff @(posedge clk) begin
		if (start) begin
			t_q       <= t;
			axis_q[0] <= snap.left_x;
			axis_q[1] <= snap.left_y;
			axis_q[2] <= snap.right_x;
			axis_q[3] <= snap.right_y;
			axis_q[4] <= snap.left_trig;
			axis_q[5] <= snap.right_trig;
		end
	end

	// Walk the lanes in index order, then the axes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			ax_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (advance) begin
						if (idx_q == LAST_IDX) begin
							state_q <= ST_AXIS;
							ax_q    <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_AXIS: begin
					if (load_axis) begin
						if (ax_q == AXIS_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							ax_q <= ax_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output valid: set on load, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_dig || load_axis) begin
			out_valid_q <= 1'b1;
		end else if (sample.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load_dig) begin
			out_q.sample_kind  <= KIND_DIGITAL;
			out_q.sample_code  <= CODE_W'(idx_q);
			out_q.is_down      <= cur.down;
			out_q.is_pressed   <= cur.pressed;
			out_q.is_released  <= cur.released;
			out_q.scalar_value <= cur.down ? Q_ONE : 16'sd0;
			out_q.hold_start   <= cur.hold;
			out_q.sample_time  <= t_q;
			out_q.last_sample  <= 1'b0;
		end else if (load_axis) begin
			out_q.sample_kind  <= KIND_AXIS;
			out_q.sample_code  <= CODE_W'(ax_q);
			out_q.is_down      <= (ax_val != 16'sd0);
			out_q.is_pressed   <= 1'b0;
			out_q.is_released  <= 1'b0;
			out_q.scalar_value <= ax_val;
			out_q.hold_start   <= 64'd0;
			out_q.sample_time  <= t_q;
			out_q.last_sample  <= (ax_q == AXIS_LAST);
		end
	end

endmodule

/* design/bhs_checker.sv */
`timescale 1ns / 1ps

module bhs_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 snap_valid,
	input logic                 snap_ready,
	input logic                 sample_valid,
	input logic                 sample_ready,
	input bhs_pkg::bhs_sample_t sample_data
);
	import bhs_pkg::*;

	// A stalled sample holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_ready |=> sample_valid && $stable(sample_data))
		else $error("sample changed while stalled");

	// A snapshot transfer is followed by a closed input
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid && snap_ready |=> !snap_ready)
		else $error("input open right after a snapshot transfer");

	// Axis samples carry no edges and no hold time
	a_axis: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && (sample_data.sample_kind == KIND_AXIS) |->
		sample_data.hold_start == 64'd0 && !sample_data.is_pressed &&
		!sample_data.is_released)
		else $error("axis sample with button fields");

	// Only the last axis closes a snapshot
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_data.last_sample |->
		sample_data.sample_kind == KIND_AXIS &&
		sample_data.sample_code == 5'(AXIS_LAST))
		else $error("last mark on wrong sample");

	// A held button reads full scale and is not released
	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && (sample_data.sample_kind == KIND_DIGITAL) &&
		sample_data.is_down |->
		sample_data.scalar_value == Q_ONE && !sample_data.is_released)
		else $error("held button sample inconsistent");

endmodule

bind button_edge_hold_sampler_unit bhs_checker u_bhs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.snap_valid   (snap.valid),
	.snap_ready   (snap.ready),
	.sample_valid (sample.valid),
	.sample_ready (sample.ready),
	.sample_data  (sample.data)
);
